// File: rtl/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg
// Shared codes, widths and control types for the bounded array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

   // Request operation codes
   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_PREPEND = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_WRITE   = 3'd4;
   localparam logic [2:0] OP_SEARCH  = 3'd5;

   // Field widths
   localparam int OP_W    = 3;
   localparam int POS_W   = 7;
   localparam int DATA_W  = 32;
   localparam int MASK_W  = 64;
   localparam int COUNT_W = 8;

   // Reported search positions and read select tree shape
   localparam int MASK_TOTAL = 2 * MASK_W;
   localparam int GRP_SIZE   = 16;
   localparam int GRP_NUM    = MASK_TOTAL / GRP_SIZE;

   localparam int DEFAULT_CAPACITY = 128;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
      logic form;
   } bale_cmd_type;

endpackage

// File: rtl/bale_controller.sv
// ----------------------------------------------------------------------------
// bale_controller
// Sequences each request through execute and result-forming steps and owns
// the handshakes on both channels.
// ----------------------------------------------------------------------------
module bale_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bale_pkg::bale_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_FORM = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // Output register can take a new word this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Take a new word when idle, or while the current one lands in the output
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FORM) && out_free);

   assign cmd.load_req = req_valid && req_ready;
   assign cmd.exec     = (state_ff == ST_EXEC);
   assign cmd.form     = (state_ff == ST_FORM) && out_free;

   // Advance the request sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_req) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FORM;
         end
         ST_FORM: begin
            if (out_free) state_in = cmd.load_req ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result word until it is taken
   always_comb begin
      if (cmd.form) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> (state_ff == ST_EXEC))
      else $error("accepted word did not enter execute");

   a_exec_to_form: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_FORM))
      else $error("execute not followed by result forming");

   a_form_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.form |=> rsp_valid_ff)
      else $error("formed result not presented");

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !cmd.load_req)
      else $error("word accepted while another executes");

endmodule

// File: rtl/bale_datapath.sv
// ----------------------------------------------------------------------------
// bale_datapath
// Row of entry cells with parallel shift and compare, entry count, a two
// level registered read select and the result register.
// ----------------------------------------------------------------------------
module bale_datapath #(
   parameter int CAPACITY = bale_pkg::DEFAULT_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bale_pkg::bale_cmd_type            cmd,
   input  logic [bale_pkg::OP_W-1:0]         req_operation,
   input  logic [bale_pkg::POS_W-1:0]        req_position,
   input  logic signed [bale_pkg::DATA_W-1:0] req_item_value,
   output logic                              rsp_ok,
   output logic signed [bale_pkg::DATA_W-1:0] rsp_read_value,
   output logic [bale_pkg::MASK_W-1:0]       rsp_mask_low,
   output logic [bale_pkg::MASK_W-1:0]       rsp_mask_high,
   output logic [bale_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > bale_pkg::POS_W) ? CNT_W : bale_pkg::POS_W;
   localparam int GSEL_W = $clog2(bale_pkg::GRP_SIZE);

   // Request register
   logic [bale_pkg::OP_W-1:0]    op_ff;
   logic [bale_pkg::POS_W-1:0]   pos_ff;
   logic [bale_pkg::DATA_W-1:0]  val_ff;

   // List state
   logic [bale_pkg::DATA_W-1:0]  cell_ff [CAPACITY];
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;

   // Execute stage results
   logic                         ok_ff;
   logic                         ok_in;
   logic [bale_pkg::MASK_TOTAL-1:0] match_ff;
   logic [bale_pkg::MASK_TOTAL-1:0] match_in;
   logic [bale_pkg::DATA_W-1:0]  grp_ff [bale_pkg::GRP_NUM];
   logic [bale_pkg::DATA_W-1:0]  grp_in [bale_pkg::GRP_NUM];
   logic [bale_pkg::DATA_W-1:0]  cell_pad [bale_pkg::MASK_TOTAL];

   // Decode
   logic [CMP_W-1:0] count_c;
   logic [CMP_W-1:0] pos_c;
   logic [CMP_W-1:0] put_pos;
   logic             is_put;
   logic             put_ok;
   logic             wr_ok;
   logic             rd_ok;

   // Result register and its next values
   logic                         rsp_ok_ff;
   logic [bale_pkg::DATA_W-1:0]  rsp_read_ff;
   logic [bale_pkg::MASK_W-1:0]  rsp_low_ff;
   logic [bale_pkg::MASK_W-1:0]  rsp_high_ff;
   logic [bale_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                         rsp_ok_in;
   logic [bale_pkg::DATA_W-1:0]  rsp_read_in;
   logic [bale_pkg::MASK_W-1:0]  rsp_low_in;
   logic [bale_pkg::MASK_W-1:0]  rsp_high_in;

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_operation;
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
   end

   assign count_c = CMP_W'(count_ff);
   assign pos_c   = CMP_W'(pos_ff);

   // Decode the operation against the current count
   always_comb begin
      is_put  = 1'b0;
      put_pos = pos_c;
      case (op_ff)
         bale_pkg::OP_APPEND: begin
            is_put  = 1'b1;
            put_pos = count_c;
         end
         bale_pkg::OP_PREPEND: begin
            is_put  = 1'b1;
            put_pos = '0;
         end
         bale_pkg::OP_INSERT: begin
            is_put  = 1'b1;
         end
         default: begin
            is_put  = 1'b0;
         end
      endcase
   end

   assign put_ok = is_put && (count_c < CMP_W'(CAPACITY)) && (put_pos <= count_c);
   assign wr_ok  = (op_ff == bale_pkg::OP_WRITE) && (pos_c < count_c);
   assign rd_ok  = (op_ff == bale_pkg::OP_READ) && (pos_c < count_c);
   assign ok_in  = put_ok || wr_ok || rd_ok;

   // Each cell shifts up from its lower neighbor or takes the new value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [bale_pkg::DATA_W-1:0] cell_in;
      if (i == 0) begin : g_first
         always_comb begin
            cell_in = cell_ff[i];
            if (put_ok && (put_pos == CMP_W'(i))) cell_in = val_ff;
            if (wr_ok && (pos_c == CMP_W'(i))) cell_in = val_ff;
         end
      end else begin : g_rest
         always_comb begin
            cell_in = cell_ff[i];
            if (put_ok) begin
               if (put_pos == CMP_W'(i)) cell_in = val_ff;
               else if (put_pos < CMP_W'(i)) cell_in = cell_ff[i-1];
            end
            if (wr_ok && (pos_c == CMP_W'(i))) cell_in = val_ff;
         end
      end
      always_ff @(posedge clock) begin
         if (cmd.exec) cell_ff[i] <= cell_in;
      end
   end

   // Pad the reported span so the mask and read select see fixed positions
   for (genvar k = 0; k < bale_pkg::MASK_TOTAL; k++) begin : g_pad
      if (k < CAPACITY) begin : g_live
         assign cell_pad[k] = cell_ff[k];
      end else begin : g_dead
         assign cell_pad[k] = '0;
      end
      assign match_in[k] = (count_c > CMP_W'(k)) && (cell_pad[k] == val_ff);
   end

   // First level of the read select: one entry out of each group
   for (genvar g = 0; g < bale_pkg::GRP_NUM; g++) begin : g_grp
      assign grp_in[g] = cell_pad[{3'(g), pos_ff[GSEL_W-1:0]}];
   end

   assign count_in = put_ok ? (count_ff + CNT_W'(1)) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff    <= ok_in;
         match_ff <= match_in;
         grp_ff   <= grp_in;
      end
   end

   // Form the result word
   always_comb begin
      rsp_ok_in   = ok_ff;
      rsp_read_in = '0;
      rsp_low_in  = '0;
      rsp_high_in = '0;
      case (op_ff)
         bale_pkg::OP_READ: begin
            rsp_read_in = ok_ff ? grp_ff[pos_ff[bale_pkg::POS_W-1:GSEL_W]] : '1;
         end
         bale_pkg::OP_SEARCH: begin
            rsp_ok_in   = |match_ff;
            rsp_low_in  = match_ff[bale_pkg::MASK_W-1:0];
            rsp_high_in = match_ff[bale_pkg::MASK_TOTAL-1:bale_pkg::MASK_W];
         end
         default: begin
            rsp_read_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.form) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_read_ff  <= rsp_read_in;
         rsp_low_ff   <= rsp_low_in;
         rsp_high_ff  <= rsp_high_in;
         rsp_count_ff <= bale_pkg::COUNT_W'(count_ff);
      end
   end

   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_mask_low    = rsp_low_ff;
   assign rsp_mask_high   = rsp_high_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_only_on_exec: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(count_ff))
      else $error("entry count moved outside execute");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && put_ok) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("successful insert did not grow the list");

endmodule

// File: rtl/bounded_array_list_engine.sv
// Each request passes through execute, then result forming. A new request
// word is taken when idle or during result forming, but not during execute;
// result forming stalls while the output register holds an untaken result.
// Every cell shifts and compares in parallel, so the request rate does not
// depend on the list length. Reset (synchronous, active high) clears the
// entry count and the handshakes; entry contents are not cleared.
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded ordered list of signed entries with append, prepend, insert, read,
// overwrite and search requests.
// ----------------------------------------------------------------------------
module bounded_array_list_engine #(
   parameter int CAPACITY = bale_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bale_pkg::OP_W-1:0]          req_operation,
   input  logic [bale_pkg::POS_W-1:0]         req_position,
   input  logic signed [bale_pkg::DATA_W-1:0] req_item_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ok,
   output logic signed [bale_pkg::DATA_W-1:0] rsp_read_value,
   output logic [bale_pkg::MASK_W-1:0]        rsp_mask_low,
   output logic [bale_pkg::MASK_W-1:0]        rsp_mask_high,
   output logic [bale_pkg::COUNT_W-1:0]       rsp_entry_count
);

   bale_pkg::bale_cmd_type cmd;

   bale_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   bale_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_mask_low    (rsp_mask_low),
      .rsp_mask_high   (rsp_mask_high),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
